// ===== hdl/jcsd_pkg.sv =====
// jcsd_pkg: types, constants and the direction classifier shared by the
// joystick calibrate/scale/direction block. No dependencies.
`default_nettype none

package jcsd_pkg;

  localparam int unsigned CAL_SAMPLES_DEF = 10;
  localparam int unsigned SAMPLE_W        = 8;
  localparam int unsigned POS_W           = 8;
  localparam int unsigned SUM_W           = 12;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned BIAS_W          = 8;
  localparam int unsigned DVD_W           = 15;  // |d| * 100 fits here
  localparam int unsigned DVS_W           = 8;

  localparam int unsigned POS_LIM  = 100;
  localparam int unsigned BIAS_LIM = 120;

  typedef enum logic [2:0] {
    DIR_NEUTRAL = 3'd0,
    DIR_RIGHT   = 3'd1,
    DIR_LEFT    = 3'd2,
    DIR_UP      = 3'd3,
    DIR_DOWN    = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Direction from bias-corrected samples; a diagonal reads as neutral.
  function automatic dir_t classify(input logic [SAMPLE_W-1:0] xs,
                                    input logic signed [BIAS_W-1:0] bx,
                                    input logic [SAMPLE_W-1:0] ys,
                                    input logic signed [BIAS_W-1:0] by);
    logic signed [9:0] cx;
    logic signed [9:0] cy;
    dir_t              res;
    cx = $signed({2'b00, xs}) - $signed({{2{bx[BIAS_W-1]}}, bx});
    cy = $signed({2'b00, ys}) - $signed({{2{by[BIAS_W-1]}}, by});
    if (cy > 10'sd78 && cy < 10'sd178) begin
      if (cx > 10'sd178)     res = DIR_RIGHT;
      else if (cx < 10'sd78) res = DIR_LEFT;
      else                   res = DIR_NEUTRAL;
    end else if (cx > 10'sd78 && cx < 10'sd178) begin
      if (cy > 10'sd178) res = DIR_UP;
      else               res = DIR_DOWN;
    end else begin
      res = DIR_NEUTRAL;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jcsd_if.sv =====
// jcsd_in_if / jcsd_out_if: valid/ready channels for sample and result words.
// Depends on jcsd_pkg for field widths.
`default_nettype none

interface jcsd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [jcsd_pkg::SAMPLE_W-1:0]     x_sample;
  logic [jcsd_pkg::SAMPLE_W-1:0]     y_sample;

  modport source (output valid, kind, x_sample, y_sample, input ready);
  modport sink   (input valid, kind, x_sample, y_sample, output ready);
endinterface

interface jcsd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [jcsd_pkg::POS_W-1:0] x_position;
  logic signed [jcsd_pkg::POS_W-1:0] y_position;
  logic [2:0]                        direction;
  logic                              calibration_done;

  modport source (output valid, x_position, y_position, direction, calibration_done,
                  input ready);
  modport sink   (input valid, x_position, y_position, direction, calibration_done,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/jcsd_div.sv =====
// jcsd_div: shared unsigned restoring divider, one quotient bit per cycle.
// Depends on jcsd_pkg (div_req_t, div_rsp_t).
`default_nettype none

module jcsd_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jcsd_pkg::div_req_t req,
  output jcsd_pkg::div_rsp_t      rsp
);

  localparam int unsigned DVD_W = jcsd_pkg::DVD_W;
  localparam int unsigned DVS_W = jcsd_pkg::DVS_W;
  localparam int unsigned ITW   = $clog2(DVD_W);
  localparam logic [ITW-1:0] LAST = ITW'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [ITW-1:0]   it_r, it_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      it_nxt  = it_r + 1'b1;
      if (it_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== hdl/joystick_calibrate_scale_direction_top.sv =====
// Joystick calibration, position scaling and direction classification.
// Depends on jcsd_pkg, jcsd_in_if/jcsd_out_if and jcsd_div.
//
//   channel   dir  handshake        word
//   in_if     in   valid/ready      kind, x_sample, y_sample
//   out_if    out  valid/ready      x_position, y_position, direction,
//                                   calibration_done
//
// A measurement word, or the calibration word that completes a run, takes
// two passes (one per axis) through the single restoring divider, which
// yields one quotient bit a cycle, before its result reaches the output
// register. Any other calibration word goes from accept straight to the
// output state, with no divider pass.
// Reset is synchronous and clears the sums, sample count, bias and sequencer.
// A finished result sits in the output register while the next word is taken;
// the sequencer holds only if a new result is ready before the old one left.
`default_nettype none

module joystick_calibrate_scale_direction_top #(
  parameter int unsigned CAL_SAMPLES = jcsd_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  jcsd_in_if.sink           in_if,
  jcsd_out_if.source        out_if
);

  localparam int unsigned SAMPLE_W = jcsd_pkg::SAMPLE_W;
  localparam int unsigned POS_W    = jcsd_pkg::POS_W;
  localparam int unsigned SUM_W    = jcsd_pkg::SUM_W;
  localparam int unsigned CNT_W    = jcsd_pkg::CNT_W;
  localparam int unsigned BIAS_W   = jcsd_pkg::BIAS_W;
  localparam int unsigned DVD_W    = jcsd_pkg::DVD_W;
  localparam int unsigned DVS_W    = jcsd_pkg::DVS_W;

  jcsd_pkg::state_t state_r, state_nxt;
  logic                       axis_r, axis_nxt;     // 0 x, 1 y
  logic                       kind_r, kind_nxt;
  logic [SAMPLE_W-1:0]        xs_r, xs_nxt, ys_r, ys_nxt;
  jcsd_pkg::dir_t             dir_r, dir_nxt;
  logic                       cdone_r, cdone_nxt;
  logic                       sign_r, sign_nxt;
  logic signed [SUM_W-1:0]    sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [BIAS_W-1:0]   bias_x_r, bias_x_nxt, bias_y_r, bias_y_nxt;
  logic signed [POS_W-1:0]    pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;

  logic                       ovalid_r, ovalid_nxt;
  logic signed [POS_W-1:0]    ox_r, ox_nxt, oy_r, oy_nxt;
  jcsd_pkg::dir_t             odir_r, odir_nxt;
  logic                       odone_r, odone_nxt;

  jcsd_pkg::div_req_t         div_req;
  jcsd_pkg::div_rsp_t         div_rsp;

  // operand setup
  logic [SAMPLE_W-1:0]        samp_sel;
  logic signed [BIAS_W-1:0]   bias_sel;
  logic signed [SUM_W-1:0]    sum_sel;
  logic signed [SUM_W-1:0]    sum_neg;
  logic [SUM_W-1:0]           sum_abs;
  logic signed [9:0]          d;
  logic signed [9:0]          d_neg;
  logic                       d_pos;
  logic [8:0]                 d_mag;
  logic [DVD_W-1:0]           prod;
  logic signed [8:0]          bias9;
  logic signed [8:0]          dvs9;
  logic [DVD_W-1:0]           op_dvd;
  logic [DVS_W-1:0]           op_dvs;
  logic                       op_neg;

  // accept path
  logic                       acc;
  logic signed [8:0]          cx_in, cy_in;
  logic [CNT_W:0]             cnt_inc;

  // result path
  logic [7:0]                 lim;
  logic [7:0]                 mag;
  logic [7:0]                 res;

  jcsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    samp_sel = axis_r ? ys_r : xs_r;
    bias_sel = axis_r ? bias_y_r : bias_x_r;
    sum_sel  = axis_r ? sum_y_r : sum_x_r;
    sum_neg  = -sum_sel;
    sum_abs  = sum_sel[SUM_W-1] ? sum_neg : sum_sel;
    d        = $signed({2'b00, samp_sel}) - $signed({{2{bias_sel[BIAS_W-1]}}, bias_sel})
               - 10'sd128;
    d_neg    = -d;
    d_pos    = (d > 10'sd0);
    d_mag    = d_pos ? d[8:0] : d_neg[8:0];
    prod     = DVD_W'(d_mag) * DVD_W'(100);
    bias9    = {bias_sel[BIAS_W-1], bias_sel};
    dvs9     = d_pos ? (9'sd127 - bias9) : (9'sd126 + bias9);
    if (kind_r) begin
      op_dvd = prod;
      op_dvs = dvs9[DVS_W-1:0];
      op_neg = !d_pos;
    end else begin
      op_dvd = DVD_W'(sum_abs);
      op_dvs = DVS_W'(CAL_SAMPLES);
      op_neg = sum_sel[SUM_W-1];
    end
  end

  always_comb begin
    acc     = (state_r == jcsd_pkg::ST_IDLE) && in_if.valid;
    cx_in   = $signed({1'b0, in_if.x_sample}) - 9'sd128;
    cy_in   = $signed({1'b0, in_if.y_sample}) - 9'sd128;
    cnt_inc = {1'b0, cnt_r} + 1'b1;

    lim = kind_r ? 8'(jcsd_pkg::POS_LIM) : 8'(jcsd_pkg::BIAS_LIM);
    mag = (div_rsp.quotient > DVD_W'(lim)) ? lim : div_rsp.quotient[7:0];
    res = sign_r ? -mag : mag;

    state_nxt  = state_r;
    axis_nxt   = axis_r;
    kind_nxt   = kind_r;
    xs_nxt     = xs_r;
    ys_nxt     = ys_r;
    dir_nxt    = dir_r;
    cdone_nxt  = cdone_r;
    sign_nxt   = sign_r;
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    cnt_nxt    = cnt_r;
    bias_x_nxt = bias_x_r;
    bias_y_nxt = bias_y_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    ovalid_nxt = ovalid_r && !out_if.ready;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    odir_nxt   = odir_r;
    odone_nxt  = odone_r;
    div_req.start    = 1'b0;
    div_req.dividend = op_dvd;
    div_req.divisor  = op_dvs;

    unique case (state_r)
      jcsd_pkg::ST_IDLE: begin
        if (acc) begin
          kind_nxt  = in_if.kind;
          xs_nxt    = in_if.x_sample;
          ys_nxt    = in_if.y_sample;
          dir_nxt   = jcsd_pkg::classify(in_if.x_sample, bias_x_r,
                                         in_if.y_sample, bias_y_r);
          axis_nxt  = 1'b0;
          cdone_nxt = 1'b0;
          pos_x_nxt = '0;
          pos_y_nxt = '0;
          if (in_if.kind) begin
            state_nxt = jcsd_pkg::ST_SETUP;
          end else begin
            sum_x_nxt = sum_x_r + SUM_W'(cx_in);
            sum_y_nxt = sum_y_r + SUM_W'(cy_in);
            if (cnt_inc >= (CNT_W+1)'(CAL_SAMPLES)) begin
              cnt_nxt   = '0;
              cdone_nxt = 1'b1;
              state_nxt = jcsd_pkg::ST_SETUP;
            end else begin
              cnt_nxt   = cnt_inc[CNT_W-1:0];
              state_nxt = jcsd_pkg::ST_OUT;
            end
          end
        end
      end
      jcsd_pkg::ST_SETUP: begin
        div_req.start = 1'b1;
        sign_nxt      = op_neg;
        state_nxt     = jcsd_pkg::ST_WAIT;
      end
      jcsd_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          if (kind_r) begin
            if (axis_r) pos_y_nxt = res;
            else        pos_x_nxt = res;
          end else begin
            if (axis_r) bias_y_nxt = res;
            else        bias_x_nxt = res;
          end
          if (axis_r) begin
            state_nxt = jcsd_pkg::ST_OUT;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = jcsd_pkg::ST_SETUP;
          end
        end
      end
      jcsd_pkg::ST_OUT: begin
        if (!ovalid_r || out_if.ready) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = pos_x_r;
          oy_nxt     = pos_y_r;
          odir_nxt   = dir_r;
          odone_nxt  = cdone_r;
          if (cdone_r) begin
            sum_x_nxt = '0;
            sum_y_nxt = '0;
          end
          state_nxt = jcsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jcsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jcsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      cnt_r    <= '0;
      bias_x_r <= '0;
      bias_y_r <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      cnt_r    <= cnt_nxt;
      bias_x_r <= bias_x_nxt;
      bias_y_r <= bias_y_nxt;
    end
    axis_r  <= axis_nxt;
    kind_r  <= kind_nxt;
    xs_r    <= xs_nxt;
    ys_r    <= ys_nxt;
    dir_r   <= dir_nxt;
    cdone_r <= cdone_nxt;
    sign_r  <= sign_nxt;
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    odir_r  <= odir_nxt;
    odone_r <= odone_nxt;
  end

  assign in_if.ready             = (state_r == jcsd_pkg::ST_IDLE);
  assign out_if.valid            = ovalid_r;
  assign out_if.x_position       = ox_r;
  assign out_if.y_position       = oy_r;
  assign out_if.direction        = odir_r;
  assign out_if.calibration_done = odone_r;

  // one word in flight: after an accept the input side closes
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input accepted while a word is in flight");

  a_bias_range: assert property (@(posedge clk) disable iff (!rst_n)
    bias_x_r >= -8'sd120 && bias_x_r <= 8'sd120 &&
    bias_y_r >= -8'sd120 && bias_y_r <= 8'sd120)
    else $error("bias outside clamp range");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == jcsd_pkg::ST_WAIT)
    else $error("divider finished outside wait state");

  a_cal_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.calibration_done |->
      out_if.x_position == '0 && out_if.y_position == '0)
    else $error("calibration result carries a position");

endmodule

`default_nettype wire

// ===== tb/joystick_calibrate_scale_direction_top_test.sv =====
// Self-checking test of joystick_calibrate_scale_direction_top: calibration runs,
// scaled positions and direction classes are predicted per word and compared.
// Depends on jcsd_pkg, jcsd_in_if/jcsd_out_if and the block's RTL.
`timescale 1ns / 1ps

module joystick_calibrate_scale_direction_top_test;

  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_MEAS = 1'b1;
  localparam int   CAL_RUN   = int'(jcsd_pkg::CAL_SAMPLES_DEF);
  localparam int   N_RANDOM  = 750;
  localparam int   STALL_LIM = 5000;
  localparam int   HOLD_LEN  = 400;

  typedef struct {
    logic       kind;
    logic [7:0] x;
    logic [7:0] y;
  } sample_t;

  typedef struct {
    logic signed [7:0] x_pos;
    logic signed [7:0] y_pos;
    jcsd_pkg::dir_t    direction;
    logic              cal_done;
  } joy_word_t;

  logic clk = 1'b0;
  logic rst_n;

  jcsd_in_if  in_if ();
  jcsd_out_if out_if ();

  joystick_calibrate_scale_direction_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #5 clk = ~clk;

  sample_t   samples_q[$];
  joy_word_t words_due[$];
  int        n_total;
  int        accepted_in = 0;
  int        offered = 0;
  int        errors = 0;
  int        idle_cycles = 0;
  int        hold_left = 0;
  bit        held_once = 1'b0;

  // Predictor state: calibration sums, count and stored bias.
  logic signed [11:0] run_sum_x = '0;
  logic signed [11:0] run_sum_y = '0;
  logic [3:0]         run_count = '0;
  logic signed [7:0]  bias_x = '0;
  logic signed [7:0]  bias_y = '0;

  function automatic logic signed [7:0] clamp_bias(logic signed [11:0] sum);
    int q;
    q = int'(sum) / CAL_RUN;
    if (q < -120) q = -120;
    if (q > 120) q = 120;
    return q[7:0];
  endfunction

  function automatic logic signed [7:0] scale_percent(logic [7:0] s, logic signed [7:0] b);
    int si;
    int bi;
    int d;
    int q;
    si = s;
    bi = b;
    d  = si - bi - 128;
    if (d > 0) q = (d * 100) / (127 - bi);
    else       q = (d * 100) / (126 + bi);
    if (q < -100) q = -100;
    if (q > 100) q = 100;
    return q[7:0];
  endfunction

  function automatic jcsd_pkg::dir_t direction_of(logic [7:0] xs, logic [7:0] ys);
    int cx;
    int cy;
    cx = xs;
    cy = ys;
    cx = cx - int'(bias_x);
    cy = cy - int'(bias_y);
    if (cy > 78 && cy < 178) begin
      if (cx > 178) return jcsd_pkg::DIR_RIGHT;
      if (cx < 78) return jcsd_pkg::DIR_LEFT;
      return jcsd_pkg::DIR_NEUTRAL;
    end
    if (cx > 78 && cx < 178) begin
      if (cy > 178) return jcsd_pkg::DIR_UP;
      return jcsd_pkg::DIR_DOWN;
    end
    return jcsd_pkg::DIR_NEUTRAL;
  endfunction

  // Direction uses the bias in force before this word is taken.
  function automatic joy_word_t calc_joy_word(sample_t s);
    joy_word_t w;
    w.direction = direction_of(s.x, s.y);
    w.x_pos     = '0;
    w.y_pos     = '0;
    w.cal_done  = 1'b0;
    if (s.kind == KIND_CAL) begin
      run_sum_x = run_sum_x + 12'(int'(s.x) - 128);
      run_sum_y = run_sum_y + 12'(int'(s.y) - 128);
      run_count = run_count + 4'd1;
      if (run_count >= CAL_RUN) begin
        bias_x    = clamp_bias(run_sum_x);
        bias_y    = clamp_bias(run_sum_y);
        run_sum_x = '0;
        run_sum_y = '0;
        run_count = '0;
        w.cal_done = 1'b1;
      end
    end else begin
      w.x_pos = scale_percent(s.x, bias_x);
      w.y_pos = scale_percent(s.y, bias_y);
    end
    return w;
  endfunction

  // rx = 0: sender idle percentage, rx = 1: receiver.
  function automatic int idle_pct(bit rx);
    if (accepted_in < 250) return rx ? 80 : 11;
    if (accepted_in < 500) return rx ? 11 : 80;
    return 0;
  endfunction

  task automatic push_sample(logic k, logic [7:0] x, logic [7:0] y);
    sample_t s;
    s.kind = k;
    s.x    = x;
    s.y    = y;
    samples_q.push_back(s);
  endtask

  // Leans towards centre, the thresholds and the rails.
  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'($urandom_range(0, 255));
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0:       return 8'd0;
        1:       return 8'd1;
        2:       return 8'd254;
        default: return 8'd255;
      endcase
    end
    if (r < 7) return 8'(($urandom_range(0, 1) ? 174 : 74) + $urandom_range(0, 8));
    return 8'(88 + $urandom_range(0, 80));
  endfunction

  task automatic push_cal_run(int mode);
    logic [7:0] x;
    logic [7:0] y;
    repeat (CAL_RUN) begin
      case (mode)
        0: begin
          x = 8'(108 + $urandom_range(0, 40));
          y = 8'(108 + $urandom_range(0, 40));
        end
        1: begin
          x = 8'($urandom_range(0, 255));
          y = 8'($urandom_range(0, 255));
        end
        2: begin
          x = 8'($urandom_range(0, 12));
          y = 8'($urandom_range(243, 255));
        end
        default: begin
          x = 8'($urandom_range(243, 255));
          y = 8'($urandom_range(0, 12));
        end
      endcase
      push_sample(KIND_CAL, x, y);
    end
  endtask

  // Sender: next word goes out once the current one has been taken.
  always @(negedge clk) begin : drive_samples
    sample_t s;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (accepted_in == offered) begin
      if (samples_q.size() == 0 || $urandom_range(99) < idle_pct(1'b0)) begin
        in_if.valid <= 1'b0;
      end else begin
        s = samples_q.pop_front();
        in_if.kind     <= s.kind;
        in_if.x_sample <= s.x;
        in_if.y_sample <= s.y;
        in_if.valid    <= 1'b1;
        offered++;
      end
    end
  end

  // Receiver, with one long hold-off while the sender keeps offering.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (!held_once && accepted_in >= 600) begin
      held_once = 1'b1;
      hold_left = HOLD_LEN;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin : check_words
    sample_t   cur;
    joy_word_t want;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_if.valid && in_if.ready) begin
        cur.kind = in_if.kind;
        cur.x    = in_if.x_sample;
        cur.y    = in_if.y_sample;
        words_due.push_back(calc_joy_word(cur));
        accepted_in++;
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d dir=%0d done=%0b", $time,
                   out_if.x_position, out_if.y_position, out_if.direction,
                   out_if.calibration_done);
          errors++;
        end else begin
          want = words_due.pop_front();
          if (out_if.x_position !== want.x_pos) begin
            $display("%0t: x_position expected %0d got %0d", $time, want.x_pos,
                     out_if.x_position);
            errors++;
          end
          if (out_if.y_position !== want.y_pos) begin
            $display("%0t: y_position expected %0d got %0d", $time, want.y_pos,
                     out_if.y_position);
            errors++;
          end
          if (out_if.direction !== want.direction) begin
            $display("%0t: direction expected %0d got %0d", $time, want.direction,
                     out_if.direction);
            errors++;
          end
          if (out_if.calibration_done !== want.cal_done) begin
            $display("%0t: calibration_done expected %0b got %0b", $time, want.cal_done,
                     out_if.calibration_done);
            errors++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIM) begin
        $display("%0t: timeout, %0d words outstanding", $time, words_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_directed;
    int r;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_CAL;
    in_if.x_sample = '0;
    in_if.y_sample = '0;
    out_if.ready   = 1'b0;

    // Zero bias: rails, centre and each direction, diagonals read neutral.
    push_sample(KIND_MEAS, 8'd0, 8'd0);
    push_sample(KIND_MEAS, 8'd255, 8'd255);
    push_sample(KIND_MEAS, 8'd128, 8'd128);
    push_sample(KIND_MEAS, 8'd200, 8'd128);
    push_sample(KIND_MEAS, 8'd10, 8'd128);
    push_sample(KIND_MEAS, 8'd128, 8'd200);
    push_sample(KIND_MEAS, 8'd128, 8'd10);
    push_sample(KIND_MEAS, 8'd10, 8'd10);
    push_sample(KIND_MEAS, 8'd200, 8'd10);
    // Run at the low rail: bias clamps to -120, then positions at the rails saturate.
    repeat (CAL_RUN) push_sample(KIND_CAL, 8'd0, 8'd0);
    push_sample(KIND_MEAS, 8'd255, 8'd0);
    push_sample(KIND_MEAS, 8'd0, 8'd255);
    push_sample(KIND_MEAS, 8'd8, 8'd8);
    n_directed = samples_q.size();

    while (samples_q.size() < n_directed + N_RANDOM) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        push_cal_run(int'($urandom_range(0, 3)));
      end else if (r == 2) begin
        push_sample(KIND_CAL, pick_level(), pick_level());
      end else begin
        repeat ($urandom_range(1, 6)) push_sample(KIND_MEAS, pick_level(), pick_level());
      end
    end
    n_total = samples_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (!(accepted_in == n_total && words_due.size() == 0)) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/jcsd_pkg.sv
hdl/jcsd_if.sv
hdl/jcsd_div.sv
hdl/joystick_calibrate_scale_direction_top.sv
tb/joystick_calibrate_scale_direction_top_test.sv
